// File: rtl/fcp_pkg.sv
// Package for the fixed chunk pool free list: widths, codes and the command struct.
`default_nettype none
package fcp_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned ReqW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OffW    = 14;
  localparam int unsigned LinkW   = 8;

  // Depth of the link store; the chunk count never exceeds it.
  localparam int unsigned LinkDepth = 128;
  localparam logic [LinkW-1:0] END_MARK = 8'd128;

  localparam int unsigned CHUNK_BYTES_DEF = 128;
  localparam int unsigned POOL_BYTES_DEF  = 16384;

  localparam logic [KindW-1:0] KIND_ALLOC    = 2'd0;
  localparam logic [KindW-1:0] KIND_FREE     = 2'd1;
  localparam logic [KindW-1:0] KIND_FREE_ALL = 2'd2;
  localparam logic [KindW-1:0] KIND_UNUSED   = 2'd3;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BIG   = 2'd2;

  typedef struct packed {
    logic capture;  // latch the request and read the link at the head
    logic execute;  // update the list and load the result register
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/fcp_ctrl.sv
// Controller for the chunk pool: two-state sequencer plus the result valid flag.
`default_nettype none
module fcp_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output fcp_pkg::cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  // The result register can take a new value when it is empty or being drained.
  assign load_out   = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.execute = load_out;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/fcp_datapath.sv
// Datapath for the chunk pool: head pointer, link memory with valid bits, result register.
`default_nettype none
module fcp_datapath #(
  parameter int unsigned CHUNK_BYTES = fcp_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned POOL_BYTES  = fcp_pkg::POOL_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fcp_pkg::cmd_t                 cmd_i,
  input  wire logic [fcp_pkg::KindW-1:0]     kind_i,
  input  wire logic [fcp_pkg::IdxW-1:0]      chunk_index_i,
  input  wire logic [fcp_pkg::ReqW-1:0]      request_bytes_i,
  output logic      [fcp_pkg::StatusW-1:0]   status_o,
  output logic      [fcp_pkg::IdxW-1:0]      granted_index_o,
  output logic      [fcp_pkg::OffW-1:0]      granted_offset_o
);

  localparam int unsigned RawCount   = POOL_BYTES / CHUNK_BYTES;
  localparam int unsigned ChunkCount =
    (RawCount > fcp_pkg::LinkDepth) ? fcp_pkg::LinkDepth : RawCount;
  localparam logic [fcp_pkg::LinkW-1:0] CountL = fcp_pkg::LinkW'(ChunkCount);
  localparam logic [fcp_pkg::LinkW-1:0] HeadInit =
    (ChunkCount > 0) ? '0 : fcp_pkg::END_MARK;
  localparam logic [fcp_pkg::ReqW-1:0] ChunkBytesL = fcp_pkg::ReqW'(CHUNK_BYTES);
  localparam int unsigned ChunkW = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned ProdW  = fcp_pkg::IdxW + ChunkW;
  localparam logic [ProdW-1:0] ChunkBytesP = ProdW'(CHUNK_BYTES);

  logic [fcp_pkg::LinkW-1:0] link_mem [fcp_pkg::LinkDepth];
  logic [fcp_pkg::LinkDepth-1:0] link_vld_q;

  logic [fcp_pkg::LinkW-1:0]   head_q, head_d;
  logic [fcp_pkg::LinkW-1:0]   rd_q;
  logic                        rd_vld_q;
  logic [fcp_pkg::KindW-1:0]   kind_q;
  logic [fcp_pkg::IdxW-1:0]    idx_q;
  logic [fcp_pkg::ReqW-1:0]    req_q;

  logic [fcp_pkg::StatusW-1:0] status_q, status_d;
  logic [fcp_pkg::IdxW-1:0]    gidx_q, gidx_d;
  logic [fcp_pkg::OffW-1:0]    goff_q, goff_d;

  logic [fcp_pkg::IdxW-1:0]    head_idx;
  logic [fcp_pkg::LinkW-1:0]   head_plus;
  logic [fcp_pkg::LinkW-1:0]   def_link;
  logic [fcp_pkg::LinkW-1:0]   next_head;
  logic [ProdW-1:0]            offset_full;
  logic                        link_wr;
  logic                        clear_all;

  assign head_idx  = head_q[fcp_pkg::IdxW-1:0];
  // A link never written since reset or the last free-all points at the next chunk, or at the end mark after the last.
  assign head_plus = {1'b0, head_idx} + fcp_pkg::LinkW'(1);
  assign def_link  = (head_plus < CountL) ? head_plus : fcp_pkg::END_MARK;
  assign next_head = rd_vld_q ? rd_q : def_link;
  assign offset_full = ProdW'(head_idx) * ChunkBytesP;

  always_comb begin
    head_d    = head_q;
    status_d  = fcp_pkg::STATUS_OK;
    gidx_d    = '0;
    goff_d    = '0;
    link_wr   = 1'b0;
    clear_all = 1'b0;
    unique case (kind_q)
      fcp_pkg::KIND_ALLOC: begin
        priority if (head_q >= CountL) begin
          status_d = fcp_pkg::STATUS_EMPTY;
        end else if (req_q > ChunkBytesL) begin
          status_d = fcp_pkg::STATUS_BIG;
        end else begin
          head_d = next_head;
          gidx_d = head_idx;
          goff_d = offset_full[fcp_pkg::OffW-1:0];
        end
      end
      fcp_pkg::KIND_FREE: begin
        if ({1'b0, idx_q} < CountL) begin
          link_wr = 1'b1;
          head_d  = {1'b0, idx_q};
        end
      end
      fcp_pkg::KIND_FREE_ALL: begin
        clear_all = 1'b1;
        head_d    = HeadInit;
      end
      fcp_pkg::KIND_UNUSED: begin
        head_d = head_q;
      end
      default: head_d = head_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q   <= link_mem[head_idx];
      kind_q <= kind_i;
      idx_q  <= chunk_index_i;
      req_q  <= request_bytes_i;
    end
    if (cmd_i.execute && link_wr) begin
      link_mem[idx_q] <= head_q;
    end
    if (cmd_i.execute) begin
      status_q <= status_d;
      gidx_q   <= gidx_d;
      goff_q   <= goff_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= HeadInit;
      link_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        rd_vld_q <= link_vld_q[head_idx];
      end
      if (cmd_i.execute) begin
        head_q <= head_d;
        if (clear_all) begin
          link_vld_q <= '0;
        end else if (link_wr) begin
          link_vld_q[idx_q] <= 1'b1;
        end
      end
    end
  end

  assign status_o         = status_q;
  assign granted_index_o  = gidx_q;
  assign granted_offset_o = goff_q;

endmodule
`default_nettype wire

// File: rtl/fixed_chunk_pool_free_list_unit.sv
// A request is captured together with a registered read of the link memory at the head of the
// free list; its result is loaded into a result register, and no new request is taken until then.
// A full result register delays the update until it drains; the next request waits meanwhile.
// Reset and free-all take effect at once: per-entry valid bits make unwritten links read as
// the in-order chain, so there is no clearing pass.
`default_nettype none
module fixed_chunk_pool_free_list_unit #(
  parameter int unsigned CHUNK_BYTES = fcp_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned POOL_BYTES  = fcp_pkg::POOL_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [fcp_pkg::KindW-1:0]     kind_i,
  input  wire logic [fcp_pkg::IdxW-1:0]      chunk_index_i,
  input  wire logic [fcp_pkg::ReqW-1:0]      request_bytes_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [fcp_pkg::StatusW-1:0]   status_o,
  output logic      [fcp_pkg::IdxW-1:0]      granted_index_o,
  output logic      [fcp_pkg::OffW-1:0]      granted_offset_o
);

  fcp_pkg::cmd_t cmd;

  fcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fcp_datapath #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .POOL_BYTES  (POOL_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (kind_i),
    .chunk_index_i    (chunk_index_i),
    .request_bytes_i  (request_bytes_i),
    .status_o         (status_o),
    .granted_index_o  (granted_index_o),
    .granted_offset_o (granted_offset_o)
  );

  // No new request is taken in the cycle right after one was accepted.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // A result is only produced for a request that was captured earlier.
  a_exec_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.execute |-> !in_ready_o)
    else $error("result loaded without a pending request");

  // Failed allocations return a zero index and offset, as checked here; non-allocate operations also do.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != fcp_pkg::STATUS_OK)) |->
      ((granted_index_o == '0) && (granted_offset_o == '0)))
    else $error("nonzero grant with error status");

endmodule
`default_nettype wire
